// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants shared by the masked byte pattern search.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_BYTES     = 24;
    localparam int LEN_BITS          = 5;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int MATCH_OFFSET_BITS = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_MID  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CARE_MASK    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LEN  = 3'd4;

    typedef logic [PATTERN_BYTES-1:0][7:0] t_pattern;

    // Compare setup for one window position.
    typedef struct packed {
        logic [7:0] pat;
        logic       care;
    } t_lane;

endpackage

`default_nettype wire

// File: hdl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, passes it on and compares its input.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell
    import mbps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    input  wire t_lane      i_lane,
    output logic      [7:0] o_byte,
    output logic            o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_lane.care || (i_byte == i_lane.pat);

endmodule

`default_nettype wire

// File: hdl/mbps_align.sv
// ----------------------------------------------------------------------------
// mbps_align
// Maps the pattern and care mask onto window positions for the used length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_align
    import mbps_pkg::*;
#(
    parameter int P_CELLS = 24
) (
    input  wire t_pattern                i_pattern,
    input  wire logic [PATTERN_BYTES-1:0] i_care,
    input  wire logic [LEN_BITS-1:0]     i_len,
    output t_lane                        o_lanes [P_CELLS],
    output logic      [LEN_BITS-1:0]     o_len
);

    localparam logic [LEN_BITS-1:0] MaxLen = LEN_BITS'(P_CELLS);

    logic [LEN_BITS-1:0] used_len;

    always_comb begin
        if (i_len == '0) begin
            used_len = LEN_BITS'(1);
        end else if (i_len > MaxLen) begin
            used_len = MaxLen;
        end else begin
            used_len = i_len;
        end
    end

    assign o_len = used_len;

    // Window position k (k bytes ago) faces pattern byte len-1-k.
    always_comb begin
        logic [LEN_BITS-1:0] idx;
        for (int k = 0; k < P_CELLS; k++) begin
            idx = used_len - LEN_BITS'(1) - LEN_BITS'(k);
            if (LEN_BITS'(k) < used_len) begin
                o_lanes[k].pat  = i_pattern[idx];
                o_lanes[k].care = i_care[idx];
            end else begin
                o_lanes[k].pat  = 8'd0;
                o_lanes[k].care = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Scans an image byte stream for the first window equal to a masked pattern.
// ----------------------------------------------------------------------------
// Input words carry one image byte and a flag marking the final byte. Each
// accepted byte enters a row of window cells; every cell compares its byte
// with the pattern byte aligned to it, and the flags are combined in the
// same cycle. One byte is taken every cycle while the result register is
// free or being drained. On the first match a word with found set and the
// window start offset appears on the output in the cycle after the byte is
// accepted; later bytes of that image are dropped. If the final byte passes
// with no match, a word with found clear and offset zero appears instead.
// A final byte resets the count and match flag for the next image.
// While a result word is held, o_stall follows the receiver's stall, so the
// input waits until that word is taken, whether or not the next byte would
// produce a result.
// Reset clears the count, the match flag, the output valid and the
// configuration registers (length reads as one). Configuration is written
// through a plain write port and applies to the next byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module masked_byte_pattern_search
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 24,
    parameter int OFFSET_BITS       = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_last_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_found,
    output logic      [MATCH_OFFSET_BITS-1:0] o_match_offset
);

    localparam int WideBits = (OFFSET_BITS > MATCH_OFFSET_BITS) ? OFFSET_BITS
                                                                : MATCH_OFFSET_BITS;

    logic [CFG_DATA_BITS-1:0] r_pat_low, r_pat_mid, r_pat_high;
    logic [PATTERN_BYTES-1:0] r_care;
    logic [LEN_BITS-1:0]      r_len;

    logic [OFFSET_BITS-1:0]       r_count;
    logic                         r_matched;
    logic                         r_out_valid;
    logic                         r_found;
    logic [MATCH_OFFSET_BITS-1:0] r_offset;

    t_pattern               pattern;
    t_lane                  lanes [MAX_PATTERN_BYTES];
    logic [LEN_BITS-1:0]    used_len;
    logic [7:0]             chain [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0] hits;

    logic                   accept;
    logic                   shift;
    logic                   counter_full;
    logic [OFFSET_BITS-1:0] n_count;
    logic                   window_full;
    logic                   match_now;
    logic [OFFSET_BITS-1:0] offset_now;
    logic [WideBits-1:0]    offset_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_mid  <= '0;
            r_pat_high <= '0;
            r_care     <= '0;
            r_len      <= LEN_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PATTERN_MID:  r_pat_mid  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                CFG_CARE_MASK:    r_care     <= i_cfg_data[PATTERN_BYTES-1:0];
                CFG_PATTERN_LEN:  r_len      <= i_cfg_data[LEN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign pattern = t_pattern'({r_pat_high, r_pat_mid, r_pat_low});

    mbps_align #(
        .P_CELLS (MAX_PATTERN_BYTES)
    ) u_align (
        .i_pattern (pattern),
        .i_care    (r_care),
        .i_len     (r_len),
        .o_lanes   (lanes),
        .o_len     (used_len)
    );

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign shift   = accept && !r_matched;

    assign chain[0] = i_data_byte;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        mbps_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(shift),
            .i_byte (chain[k]),
            .i_lane (lanes[k]),
            .o_byte (chain[k+1]),
            .o_hit  (hits[k])
        );
    end

    assign counter_full = &r_count;
    assign n_count      = r_count + OFFSET_BITS'(1);
    assign window_full  = n_count >= OFFSET_BITS'(used_len);
    assign match_now    = shift && !counter_full && window_full && (&hits);
    assign offset_now   = n_count - OFFSET_BITS'(used_len);
    assign offset_wide  = WideBits'(offset_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_matched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last_byte) begin
                    r_count   <= '0;
                    r_matched <= 1'b0;
                end else if (!r_matched) begin
                    r_matched <= match_now;
                    if (!counter_full) begin
                        r_count <= n_count;
                    end
                end
            end
            if (accept && (match_now || (i_last_byte && !r_matched))) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (match_now || (i_last_byte && !r_matched))) begin
            r_found  <= match_now;
            r_offset <= match_now ? offset_wide[MATCH_OFFSET_BITS-1:0] : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, accept && i_last_byte,
        r_count == '0 && !r_matched, "image state not cleared after final byte")
    `ASSERT_NEXT(a_match_reports, i_clk, i_rst_n, match_now,
        r_out_valid && r_found, "match did not produce a found word")
    `ASSERT_SAME(a_miss_offset, i_clk, i_rst_n, r_out_valid && !r_found,
        r_offset == '0, "not-found word carries a nonzero offset")

endmodule

`default_nettype wire
